// ===== src/pdcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdcc_pkg: shared definitions for the protein/DNA clash checker
// Operation codes, sequencer states, field widths and the status struct that
// the distance unit returns to the sequencer.
// ----------------------------------------------------------------------------
package pdcc_pkg;

    // Default capacities and the exclusion margin around the binding site.
    localparam int MAX_ATOMS_DEF      = 4096;
    localparam int MAX_POINTS_DEF     = 1024;
    localparam int EXCLUDE_MARGIN_DEF = 10;

    // Field and datapath widths.
    localparam int COORD_W = 24;                // Q.8 coordinate or Q.16 coefficient
    localparam int ACC_W   = 52;                // exact sum of three products plus offset
    localparam int XF_W    = ACC_W - 16;        // transformed coordinate in Q.8
    localparam int DIFF_W  = XF_W + 1;          // difference against a DNA point
    localparam int MAG_W   = 10;                // magnitude below 4.0 in Q.8
    localparam int SUM_W   = 2 * MAG_W + 2;     // sum of three squares

    // Closeness limits: 4.0 per axis in Q.8 and 16.0 squared in Q.16.
    localparam int LIMIT_AXIS = 4 << 8;
    localparam int LIMIT_SQ   = 16 << 16;

    // Operation codes of the input word.
    typedef enum logic [1:0] {
        OP_LOAD_XF   = 2'd0,
        OP_LOAD_ATOM = 2'd1,
        OP_LOAD_PT   = 2'd2,
        OP_CHECK     = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ATOM_RD,
        S_XFORM,
        S_PT_RD,
        S_PT_TEST,
        S_DIST,
        S_DONE
    } t_state;

    // Status from the distance unit.
    typedef struct packed {
        logic done;
        logic hit;
    } t_dist_stat;

endpackage

// ===== src/pdcc_mac.sv =====
// ----------------------------------------------------------------------------
// pdcc_mac: shared multiply-accumulate unit
// One signed 24x24 multiplier feeding a wide accumulator; the sequencer runs
// it four times per output row of the rigid transform.
// ----------------------------------------------------------------------------
module pdcc_mac
    import pdcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_clr,
    input  logic                     i_en,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output logic signed [ACC_W-1:0]   o_next
);

    logic signed [ACC_W-1:0]     r_acc;
    logic signed [2*COORD_W-1:0] prod;

    // Product plus the running sum, restarted on the first term of a row.
    assign prod   = i_x * i_y;
    assign o_next = (i_clr ? ACC_W'(0) : r_acc) + ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= o_next;
        end
    end

endmodule

// ===== src/pdcc_dist.sv =====
// ----------------------------------------------------------------------------
// pdcc_dist: squared distance test for one atom/point pair
// Checks each axis against 4.0, then sums the three squares with a single
// small multiplier, one axis per cycle, and compares against 16.0.
// ----------------------------------------------------------------------------
module pdcc_dist
    import pdcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [XF_W-1:0]    i_tx,
    input  logic signed [XF_W-1:0]    i_ty,
    input  logic signed [XF_W-1:0]    i_tz,
    input  logic [3*COORD_W-1:0]      i_pt,
    output t_dist_stat                o_stat
);

    logic                    r_busy;
    logic [1:0]              r_k;
    logic                    r_ok;
    logic [MAG_W-1:0]        r_mag [3];
    logic [SUM_W-1:0]        r_sum;

    logic signed [DIFF_W-1:0] d [3];
    logic [MAG_W-1:0]         mag [3];
    logic [2:0]               near;
    logic [2*MAG_W-1:0]       sq;
    logic [SUM_W-1:0]         n_sum;

    // Exact differences and the per-axis window test.
    always_comb begin
        d[0] = DIFF_W'(i_tx) - DIFF_W'($signed(i_pt[3*COORD_W-1:2*COORD_W]));
        d[1] = DIFF_W'(i_ty) - DIFF_W'($signed(i_pt[2*COORD_W-1:COORD_W]));
        d[2] = DIFF_W'(i_tz) - DIFF_W'($signed(i_pt[COORD_W-1:0]));
        for (int a = 0; a < 3; a++) begin
            near[a] = (d[a] > -DIFF_W'(LIMIT_AXIS)) && (d[a] < DIFF_W'(LIMIT_AXIS));
            mag[a]  = d[a][DIFF_W-1] ? MAG_W'(-d[a]) : MAG_W'(d[a]);
        end
    end

    // One square per cycle into the running sum.
    assign sq    = r_mag[r_k] * r_mag[r_k];
    assign n_sum = r_sum + SUM_W'(sq);

    assign o_stat.done = r_busy && (!r_ok || r_k == 2'd2);
    assign o_stat.hit  = r_ok && (n_sum < SUM_W'(LIMIT_SQ));

    // Control: busy from start until the last square or an axis miss.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_k    <= 2'd0;
        end else if (o_stat.done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
        end
    end

    // Operands and the partial sum.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_ok  <= &near;
            r_sum <= '0;
            for (int a = 0; a < 3; a++) begin
                r_mag[a] <= mag[a];
            end
        end else if (r_busy) begin
            r_sum <= n_sum;
        end
    end

    // The unit never reports done while idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |-> $past(i_start) || $past(r_busy))
        else $error("distance unit done without a start");

    // A hit requires every axis inside the window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && o_stat.hit) |-> r_ok)
        else $error("distance hit with an axis outside the window");

    // The axis counter never passes the third axis.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k != 2'd3))
        else $error("distance axis counter out of range");

endmodule

// ===== src/protein_dna_clash_check.sv =====
// ----------------------------------------------------------------------------
// protein_dna_clash_check: rigid-transform atom/DNA collision check
// Holds a 3x4 transform, an atom table and a DNA point table; a check word
// transforms each atom and tests it against each window point outside the site.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_operation .. i_atom_count
//  out     | output    | o_out_valid / i_out_ready | o_overlap, o_count_error
//
// Load words are taken only while the sequencer is idle. A check runs each
// atom through the shared multiply-accumulate unit and each pair that
// survives the site exclusion through the one-multiplier distance unit.
// The check stops at the first hit. Reset clears control state only; the
// stores are undefined until written. A waiting result does not block loads.
// ----------------------------------------------------------------------------
module protein_dna_clash_check
    import pdcc_pkg::*;
#(
    parameter int MAX_ATOMS      = MAX_ATOMS_DEF,
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int EXCLUDE_MARGIN = EXCLUDE_MARGIN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_operation,
    input  logic [11:0]               i_item_index,
    input  logic signed [COORD_W-1:0] i_val_a,
    input  logic signed [COORD_W-1:0] i_val_b,
    input  logic signed [COORD_W-1:0] i_val_c,
    input  logic signed [COORD_W-1:0] i_val_d,
    input  logic [15:0]               i_site_pos,
    input  logic [11:0]               i_site_len,
    input  logic [15:0]               i_window_first,
    input  logic [15:0]               i_window_end,
    input  logic [12:0]               i_atom_count,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_overlap,
    output logic                      o_count_error
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    t_state r_state, n_state;

    // Stores.
    logic [3*COORD_W-1:0]      r_atom_mem [MAX_ATOMS];
    logic [3*COORD_W-1:0]      r_pt_mem   [MAX_POINTS];
    logic signed [COORD_W-1:0] r_xf [12];
    logic [3*COORD_W-1:0]      r_atom_q;
    logic [3*COORD_W-1:0]      r_pt_q;

    // Check parameters and loop counters.
    logic [16:0]              r_centre;
    logic [12:0]              r_reach;
    logic [16:0]              r_end;
    logic [12:0]              r_natoms;
    logic [12:0]              r_ai;
    logic [16:0]              r_j;
    logic [PW-1:0]            r_pj;
    logic [3:0]               r_step;
    logic signed [XF_W-1:0]   r_t [3];

    // Output register.
    logic                     r_out_valid;
    logic                     r_overlap;
    logic                     r_cerr;
    logic                     r_hit;

    // Decoded control.
    logic                     accept;
    logic                     is_check;
    logic                     cap_err;
    logic                     empty;
    logic                     mac_en;
    logic                     dist_start;
    logic                     excluded;
    logic                     last_pt;
    logic                     last_atom;
    logic signed [17:0]       sdiff;
    logic signed [COORD_W-1:0] mac_x;
    logic signed [ACC_W-1:0]  mac_next;
    logic signed [ACC_W-1:0]  rounded;
    t_dist_stat               dist_stat;

    // Handshake: a check waits until the result register can take its answer.
    assign is_check   = (t_op'(i_operation) == OP_CHECK);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready || !is_check);
    assign accept     = i_in_valid && o_in_ready;

    assign cap_err = (17'(i_atom_count) > 17'(MAX_ATOMS)) ||
                     ((i_window_end > i_window_first) &&
                      (17'(i_window_end - i_window_first) > 17'(MAX_POINTS)));
    assign empty   = (i_atom_count == 13'd0) || (i_window_end <= i_window_first);

    // Site exclusion and loop ends.
    assign sdiff     = $signed({1'b0, r_centre}) - $signed({1'b0, r_j});
    assign excluded  = (sdiff <= $signed({5'd0, r_reach})) &&
                       (sdiff >= -$signed({5'd0, r_reach}));
    assign last_pt   = (r_j + 17'd1 == r_end);
    assign last_atom = (r_ai + 13'd1 == r_natoms);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && is_check) begin
                    n_state = (cap_err || empty) ? S_DONE : S_ATOM_RD;
                end
            end
            S_ATOM_RD: n_state = S_XFORM;
            S_XFORM: begin
                if (r_step == 4'd11) begin
                    n_state = S_PT_RD;
                end
            end
            S_PT_RD: n_state = S_PT_TEST;
            S_PT_TEST: begin
                if (!excluded) begin
                    n_state = S_DIST;
                end else if (!last_pt) begin
                    n_state = S_PT_RD;
                end else begin
                    n_state = last_atom ? S_DONE : S_ATOM_RD;
                end
            end
            S_DIST: begin
                if (dist_stat.done) begin
                    if (dist_stat.hit || (last_pt && last_atom)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = last_pt ? S_ATOM_RD : S_PT_RD;
                    end
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        mac_en     = 1'b0;
        dist_start = 1'b0;
        case (r_state)
            S_XFORM:   mac_en = 1'b1;
            S_PT_TEST: dist_start = !excluded;
            default: begin
                mac_en     = 1'b0;
                dist_start = 1'b0;
            end
        endcase
    end

    // Multiplier operands: atom coordinate, or the Q.16 unit for translation.
    always_comb begin
        case (r_step[1:0])
            2'd0:    mac_x = $signed(r_atom_q[3*COORD_W-1:2*COORD_W]);
            2'd1:    mac_x = $signed(r_atom_q[2*COORD_W-1:COORD_W]);
            2'd2:    mac_x = $signed(r_atom_q[COORD_W-1:0]);
            default: mac_x = COORD_W'(1 << 16);
        endcase
    end

    assign rounded = (mac_next + ACC_W'(1 << 15)) >>> 16;

    pdcc_mac u_mac (
        .i_clk  (i_clk),
        .i_clr  (r_step[1:0] == 2'd0),
        .i_en   (mac_en),
        .i_x    (mac_x),
        .i_y    (r_xf[r_step]),
        .o_next (mac_next)
    );

    pdcc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_tx    (r_t[0]),
        .i_ty    (r_t[1]),
        .i_tz    (r_t[2]),
        .i_pt    (r_pt_q),
        .o_stat  (dist_stat)
    );

    // Store writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_operation) == OP_LOAD_ATOM &&
            17'(i_item_index) < 17'(MAX_ATOMS)) begin
            r_atom_mem[AW'(i_item_index)] <= {i_val_a, i_val_b, i_val_c};
        end
        r_atom_q <= r_atom_mem[AW'(r_ai)];
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_operation) == OP_LOAD_PT &&
            17'(i_item_index) < 17'(MAX_POINTS)) begin
            r_pt_mem[PW'(i_item_index)] <= {i_val_a, i_val_b, i_val_c};
        end
        r_pt_q <= r_pt_mem[r_pj];
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_op'(i_operation) == OP_LOAD_XF && i_item_index < 12'd3) begin
            r_xf[{i_item_index[1:0], 2'd0}] <= i_val_a;
            r_xf[{i_item_index[1:0], 2'd1}] <= i_val_b;
            r_xf[{i_item_index[1:0], 2'd2}] <= i_val_c;
            r_xf[{i_item_index[1:0], 2'd3}] <= i_val_d;
        end
    end

    // Check setup, loop counters and transformed coordinates.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && is_check) begin
            r_centre <= 17'(i_site_pos) + 17'(i_site_len[11:1]);
            r_reach  <= 13'(i_site_len[11:1]) + 13'(EXCLUDE_MARGIN);
            r_end    <= 17'(i_window_end);
            r_natoms <= i_atom_count;
            r_ai     <= '0;
            r_j      <= 17'(i_window_first);
            r_pj     <= '0;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_cerr   <= cap_err;
        end
        if (mac_en) begin
            r_step <= (r_step == 4'd11) ? 4'd0 : r_step + 4'd1;
            if (r_step[1:0] == 2'd3) begin
                r_t[r_step[3:2]] <= rounded[XF_W-1:0];
            end
        end
        if ((r_state == S_PT_TEST && excluded) ||
            (r_state == S_DIST && dist_stat.done && !dist_stat.hit)) begin
            if (last_pt) begin
                r_ai <= r_ai + 13'd1;
                r_j  <= r_j - 17'(r_pj);
                r_pj <= '0;
            end else begin
                r_j  <= r_j + 17'd1;
                r_pj <= r_pj + PW'(1);
            end
        end
        if (r_state == S_DIST && dist_stat.done && dist_stat.hit) begin
            r_hit <= 1'b1;
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
                r_overlap   <= r_hit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_overlap     = r_overlap;
    assign o_count_error = r_cerr;

    // Input is only taken while the sequencer is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    // A capacity error never reports an overlap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_count_error) |-> !o_overlap)
        else $error("overlap reported with a count error");

    // The transform step counter stays within the twelve coefficients.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XFORM) |-> (r_step < 4'd12))
        else $error("transform step out of range");

    // Finishing a check always loads the result register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_out_valid)
        else $error("check finished without a result");

endmodule

// ===== test/protein_dna_clash_check_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protein_dna_clash_check_tb: self-checking bench for the clash checker
// A queue of words is built up front and pushed through the input channel
// with random stalls. Every accepted load word updates a model of the transform,
// atom and DNA tables, and each check word predicts an overlap/error verdict.
// Verdicts are then compared against the output channel in order.
// ----------------------------------------------------------------------------
module protein_dna_clash_check_tb;
    import pdcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int QUIET_TAIL     = 150;
    localparam int N_RANDOM       = 1100;

    // One word of the input channel.
    typedef struct {
        t_op         op;
        logic [11:0] idx;
        logic [23:0] a, b, c, d;
        logic [15:0] pos;
        logic [11:0] len;
        logic [15:0] first, wend;
        logic [12:0] natoms;
    } t_clash_word;

    typedef struct {
        bit overlap;
        bit cnt_err;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_out_valid, o_overlap, o_count_error;
    t_clash_word cur_w;

    t_clash_word word_q[$];
    t_verdict    verdict_q[$];

    // Mirror of the block's tables.
    longint xf_coef[12];
    longint atom_xyz[MAX_ATOMS_DEF][3];
    longint pt_xyz[MAX_POINTS_DEF][3];

    // Generator bookkeeping: which entries have been written.
    bit atom_set[MAX_ATOMS_DEF];
    bit pt_set[MAX_POINTS_DEF];
    int atom_run = 0;
    int pt_run = 0;

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  in_took = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    protein_dna_clash_check DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (cur_w.op),
        .i_item_index   (cur_w.idx),
        .i_val_a        (cur_w.a),
        .i_val_b        (cur_w.b),
        .i_val_c        (cur_w.c),
        .i_val_d        (cur_w.d),
        .i_site_pos     (cur_w.pos),
        .i_site_len     (cur_w.len),
        .i_window_first (cur_w.first),
        .i_window_end   (cur_w.wend),
        .i_atom_count   (cur_w.natoms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_overlap      (o_overlap),
        .o_count_error  (o_count_error)
    );

    // Sign-extend a 24-bit field.
    function automatic longint sx(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    // Apply one accepted word to the table mirror; returns 1 with a verdict
    // for check words.
    function automatic bit predict_clash(t_clash_word w, output t_verdict v);
        longint t[3];
        longint s, dx, dy, dz;
        int centre, reach, nsteps;
        bit hit;
        v = '{0, 0};
        case (w.op)
            OP_LOAD_XF: begin
                if (w.idx < 3) begin
                    xf_coef[w.idx*4 + 0] = sx(w.a);
                    xf_coef[w.idx*4 + 1] = sx(w.b);
                    xf_coef[w.idx*4 + 2] = sx(w.c);
                    xf_coef[w.idx*4 + 3] = sx(w.d);
                end
                return 0;
            end
            OP_LOAD_ATOM: begin
                atom_xyz[w.idx] = '{sx(w.a), sx(w.b), sx(w.c)};
                return 0;
            end
            OP_LOAD_PT: begin
                if (w.idx < MAX_POINTS_DEF)
                    pt_xyz[w.idx] = '{sx(w.a), sx(w.b), sx(w.c)};
                return 0;
            end
            default: ;
        endcase
        nsteps = int'(w.wend) - int'(w.first);
        if (w.natoms > MAX_ATOMS_DEF || nsteps > MAX_POINTS_DEF) begin
            v.cnt_err = 1'b1;
            return 1;
        end
        centre = int'(w.pos) + int'(w.len >> 1);
        reach  = int'(w.len >> 1) + EXCLUDE_MARGIN_DEF;
        hit = 1'b0;
        for (int i = 0; i < w.natoms && !hit; i++) begin
            for (int r = 0; r < 3; r++) begin
                s = xf_coef[r*4+3] * 65536 + atom_xyz[i][0] * xf_coef[r*4]
                    + atom_xyz[i][1] * xf_coef[r*4+1] + atom_xyz[i][2] * xf_coef[r*4+2];
                t[r] = (s + 32768) >>> 16;
            end
            for (int j = w.first; j < w.wend && !hit; j++) begin
                // Steps around the binding site are never tested.
                if ((centre - j <= reach) && (j - centre <= reach))
                    continue;
                dx = t[0] - pt_xyz[j - w.first][0];
                dy = t[1] - pt_xyz[j - w.first][1];
                dz = t[2] - pt_xyz[j - w.first][2];
                if (dx >= LIMIT_AXIS || -dx >= LIMIT_AXIS || dy >= LIMIT_AXIS ||
                    -dy >= LIMIT_AXIS || dz >= LIMIT_AXIS || -dz >= LIMIT_AXIS)
                    continue;
                if (dx*dx + dy*dy + dz*dz < LIMIT_SQ)
                    hit = 1'b1;
            end
        end
        v.overlap = hit;
        return 1;
    endfunction

    // Coordinate: mostly within a few angstrom of the origin, sometimes anywhere.
    function automatic logic [23:0] rand_coord();
        if ($urandom_range(0, 9) < 8)
            return 24'(int'($urandom_range(0, 2400)) - 1200);
        return 24'($urandom);
    endfunction

    // Word with every field random; callers overwrite what matters.
    function automatic t_clash_word noise_word(t_op op);
        t_clash_word w;
        w.op = op;
        w.idx = 12'($urandom);
        w.a = 24'($urandom); w.b = 24'($urandom);
        w.c = 24'($urandom); w.d = 24'($urandom);
        w.pos = 16'($urandom); w.len = 12'($urandom);
        w.first = 16'($urandom); w.wend = 16'($urandom);
        w.natoms = 13'($urandom);
        return w;
    endfunction

    // Queue a word and track which table entries become readable.
    task automatic queue_word(t_clash_word w);
        word_q.push_back(w);
        if (w.op == OP_LOAD_ATOM) begin
            atom_set[w.idx] = 1'b1;
            while (atom_run < MAX_ATOMS_DEF && atom_set[atom_run]) atom_run++;
        end
        if (w.op == OP_LOAD_PT && w.idx < MAX_POINTS_DEF) begin
            pt_set[w.idx] = 1'b1;
            while (pt_run < MAX_POINTS_DEF && pt_set[pt_run]) pt_run++;
        end
    endtask

    task automatic queue_load(t_op op, int idx, int x, int y, int z, int tr);
        t_clash_word w;
        w = noise_word(op);
        w.idx = 12'(idx);
        w.a = 24'(x); w.b = 24'(y); w.c = 24'(z); w.d = 24'(tr);
        queue_word(w);
    endtask

    task automatic queue_check(int natoms, int first, int wend, int pos, int len);
        t_clash_word w;
        w = noise_word(OP_CHECK);
        w.natoms = 13'(natoms);
        w.first = 16'(first); w.wend = 16'(wend);
        w.pos = 16'(pos); w.len = 12'(len);
        queue_word(w);
    endtask

    // Random check that only reads written entries.
    task automatic queue_random_check();
        int na, np, first, kind;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            queue_check($urandom_range(MAX_ATOMS_DEF + 1, 8191), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom, $urandom);
        end else if (kind == 1) begin
            first = $urandom_range(0, 64000);
            queue_check($urandom_range(0, atom_run), first,
                        first + $urandom_range(MAX_POINTS_DEF + 1, 1500), $urandom, $urandom);
        end else if (kind == 2) begin
            queue_check(0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom, $urandom);
        end else if (kind == 3) begin
            first = $urandom_range(1, 65535);
            queue_check($urandom_range(0, atom_run > 8 ? 8 : atom_run), first,
                        $urandom_range(0, first), $urandom, $urandom);
        end else begin
            na = (kind == 4) ? $urandom_range(0, atom_run > 32 ? 32 : atom_run)
                             : $urandom_range(1, atom_run > 8 ? 8 : atom_run);
            np = $urandom_range(1, pt_run > 16 ? 16 : pt_run);
            first = $urandom_range(0, 65535 - np);
            queue_check(na, first, first + np,
                        (first + $urandom_range(0, np + 40) - 30) & 16'hffff,
                        (kind == 5) ? $urandom_range(0, 4095) : $urandom_range(0, 24));
        end
    endtask

    // Build the whole stimulus.
    initial begin
        t_clash_word w;
        int k, r;
        // Identity transform, then a row index past the end that must be ignored.
        queue_load(OP_LOAD_XF, 0, 65536, 0, 0, 0);
        queue_load(OP_LOAD_XF, 1, 0, 65536, 0, 0);
        queue_load(OP_LOAD_XF, 2, 0, 0, 65536, 0);
        queue_load(OP_LOAD_XF, 4095, -8388608, 8388607, 12345, -8388608);
        // Atoms and points that sit close together, plus extreme values.
        queue_load(OP_LOAD_ATOM, 0, 0, 0, 0, 0);
        queue_load(OP_LOAD_ATOM, 1, 8388607, -8388608, 8388607, 0);
        queue_load(OP_LOAD_PT, 0, 1023, 0, 0, 0);
        queue_load(OP_LOAD_PT, 1, 600, 600, 600, 0);
        queue_load(OP_LOAD_PT, 2, -8388608, 8388607, -8388608, 0);
        // Point offsets past capacity are dropped.
        queue_load(OP_LOAD_PT, 4095, 0, 0, 0, 0);
        queue_load(OP_LOAD_PT, MAX_POINTS_DEF, 0, 0, 0, 0);
        // Hit with the site far away, then the same pair inside the exclusion.
        queue_check(1, 100, 101, 0, 0);
        queue_check(1, 100, 101, 95, 4);
        queue_check(1, 101, 102, 0, 0);
        queue_check(2, 65532, 65535, 0, 4095);
        queue_check(2, 0, 3, 65535, 4095);
        // Empty window, no atoms, and both capacity errors.
        queue_check(2, 500, 500, 0, 0);
        queue_check(2, 65535, 0, 0, 0);
        queue_check(0, 0, MAX_POINTS_DEF, 0, 0);
        queue_check(MAX_ATOMS_DEF + 1, 0, 1, 0, 0);
        queue_check(8191, 65535, 65535, 65535, 4095);
        queue_check(1, 0, MAX_POINTS_DEF + 1, 0, 0);
        queue_check(0, 0, 65535, 0, 0);

        // Random part: mostly loads that grow the tables, then checks over them.
        for (k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                w = noise_word(OP_LOAD_ATOM);
                if ($urandom_range(0, 9) != 0)
                    w.idx = 12'($urandom_range(0, atom_run > 40 ? 40 : atom_run));
                w.a = rand_coord(); w.b = rand_coord(); w.c = rand_coord();
                queue_word(w);
            end else if (r < 58) begin
                w = noise_word(OP_LOAD_PT);
                if ($urandom_range(0, 9) != 0)
                    w.idx = 12'($urandom_range(0, pt_run > 24 ? 24 : pt_run));
                w.a = rand_coord(); w.b = rand_coord(); w.c = rand_coord();
                queue_word(w);
            end else if (r < 66) begin
                w = noise_word(OP_LOAD_XF);
                if ($urandom_range(0, 9) != 0) w.idx = 12'($urandom_range(0, 2));
                if ($urandom_range(0, 9) < 7) begin
                    // Near-identity row so that hits stay reachable.
                    w.a = 24'(int'($urandom_range(0, 16384)) - 8192);
                    w.b = 24'(int'($urandom_range(0, 16384)) - 8192);
                    w.c = 24'(int'($urandom_range(0, 16384)) - 8192);
                    w.d = 24'(int'($urandom_range(0, 800)) - 400);
                    case (w.idx)
                        0: w.a = w.a + 24'd65536;
                        1: w.b = w.b + 24'd65536;
                        2: w.c = w.c + 24'd65536;
                        default: ;
                    endcase
                end
                queue_word(w);
            end else begin
                queue_random_check();
            end
        end
    end

    // Reset, then wait for the queue to drain and the last verdict to arrive.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (word_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Input driver: holds a word until accepted, with random gaps between words.
    always @(negedge i_clk) begin
        bit keep;
        keep = i_in_valid && !in_took;
        if (i_rst_n && !keep) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (word_q.size() > 0) begin
                if (word_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 18);
                end else begin
                    cur_w = word_q.pop_front();
                    keep = 1'b1;
                end
            end
        end
        i_in_valid <= keep;
    end

    // Output stall driver.
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (word_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted word, check each accepted result word.
    always @(posedge i_clk) begin
        t_verdict v, want;
        bit fired;
        fired = 1'b0;
        in_took = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            in_took = 1'b1;
            fired = 1'b1;
            if (predict_clash(cur_w, v))
                verdict_q.push_back(v);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            fired = 1'b1;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with none expected: overlap=%0b count_error=%0b",
                             o_overlap, o_count_error);
            end else begin
                want = verdict_q.pop_front();
                if (o_overlap !== want.overlap || o_count_error !== want.cnt_err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: overlap exp %0b got %0b, count_error exp %0b got %0b",
                                 want.overlap, o_overlap, want.cnt_err, o_count_error);
                end
            end
        end
        // Watchdog on cycles without any accepted input or result word.
        if (fired || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
src/pdcc_pkg.sv
src/pdcc_mac.sv
src/pdcc_dist.sv
src/protein_dna_clash_check.sv
test/protein_dna_clash_check_tb.sv
